FILE: rtl/core/xoodoo_pkg.sv
// Shared types, sizes and round constants for the Xoodoo permutation core.
`timescale 1ns / 1ps
package xoodoo_pkg;

    localparam int LANE_W = 32;
    localparam int LANES  = 12;
    localparam int ROUNDS = 12;
    localparam int RC_W   = 10;

    // Full 384-bit state, index = 4*plane + column
    typedef logic [LANES-1:0][LANE_W-1:0] t_state;
    typedef logic [LANE_W-1:0]            t_lane;
    typedef logic [RC_W-1:0]              t_rc;

    localparam t_rc RC_TBL [ROUNDS] = '{
        10'h058, 10'h038, 10'h3c0, 10'h0d0, 10'h120, 10'h014,
        10'h060, 10'h02c, 10'h380, 10'h0f0, 10'h1a0, 10'h012
    };

    // Rotate a lane left by n, n in 1..31
    function automatic t_lane rotl(input t_lane v, input int n);
        rotl = (v << n) | (v >> (LANE_W - n));
    endfunction

endpackage

FILE: rtl/core/xoodoo_round.sv
// One Xoodoo round followed by its pipeline register.
`timescale 1ns / 1ps
module xoodoo_round
    import xoodoo_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_state i_state,
    input  t_rc    i_rc,
    output logic   o_vld,
    output t_state o_state
);

    logic   r_vld;
    t_state r_state;
    t_state n_state;

    // theta, rho-west, iota, chi, rho-east
    always_comb begin
        t_lane  p  [4];
        t_lane  e  [4];
        t_lane  b0 [4];
        t_lane  b1 [4];
        t_lane  b2 [4];
        t_state a;
        a = i_state;
        // column parity and its spread
        for (int x = 0; x < 4; x++) begin
            p[x] = a[x] ^ a[x+4] ^ a[x+8];
        end
        for (int x = 0; x < 4; x++) begin
            e[x] = rotl(p[(x+3)%4], 5) ^ rotl(p[(x+3)%4], 14);
        end
        for (int k = 0; k < LANES; k++) begin
            a[k] = a[k] ^ e[k%4];
        end
        // plane shuffle
        for (int x = 0; x < 4; x++) begin
            b0[x] = a[x];
            b1[x] = a[4 + (x+3)%4];
            b2[x] = rotl(a[8+x], 11);
        end
        b0[0] = b0[0] ^ {{(LANE_W-RC_W){1'b0}}, i_rc};
        // nonlinear step and east shuffle
        n_state = '0;
        for (int x = 0; x < 4; x++) begin
            n_state[x]           = b0[x] ^ (~b1[x] & b2[x]);
            n_state[4+x]         = rotl(b1[x] ^ (~b2[x] & b0[x]), 1);
            n_state[8+(x+2)%4]   = rotl(b2[x] ^ (~b0[x] & b1[x]), 8);
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_vld   = r_vld;
    assign o_state = r_state;

endmodule

FILE: rtl/core/xoodoo_permutation_384_top.sv
// Top level: twelve-stage unrolled Xoodoo permutation pipeline.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  input   | in  | start, busy          | i_in_lane_0 .. i_in_lane_11
//  result  | out | o_valid (one cycle)  | o_out_lane_0 .. o_out_lane_11
//
// One round per register stage; a word taken at an edge passes through all
// twelve round registers, appears on the result ports for one cycle, marked
// by o_valid, and is taken by the receiver while o_valid is high.
// A new word is taken every cycle: busy is always low.
// Synchronous active-low reset clears the stage valid bits only.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module xoodoo_permutation_384_top
    import xoodoo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_in_lane_0,
    input  logic [31:0] i_in_lane_1,
    input  logic [31:0] i_in_lane_2,
    input  logic [31:0] i_in_lane_3,
    input  logic [31:0] i_in_lane_4,
    input  logic [31:0] i_in_lane_5,
    input  logic [31:0] i_in_lane_6,
    input  logic [31:0] i_in_lane_7,
    input  logic [31:0] i_in_lane_8,
    input  logic [31:0] i_in_lane_9,
    input  logic [31:0] i_in_lane_10,
    input  logic [31:0] i_in_lane_11,
    output logic        o_valid,
    output logic [31:0] o_out_lane_0,
    output logic [31:0] o_out_lane_1,
    output logic [31:0] o_out_lane_2,
    output logic [31:0] o_out_lane_3,
    output logic [31:0] o_out_lane_4,
    output logic [31:0] o_out_lane_5,
    output logic [31:0] o_out_lane_6,
    output logic [31:0] o_out_lane_7,
    output logic [31:0] o_out_lane_8,
    output logic [31:0] o_out_lane_9,
    output logic [31:0] o_out_lane_10,
    output logic [31:0] o_out_lane_11
);

    logic   w_vld   [ROUNDS+1];
    t_state w_state [ROUNDS+1];

    // pipeline never stalls
    assign busy = 1'b0;

    // pack input word
    assign w_vld[0]   = start;
    assign w_state[0] = {i_in_lane_11, i_in_lane_10, i_in_lane_9, i_in_lane_8,
                         i_in_lane_7,  i_in_lane_6,  i_in_lane_5, i_in_lane_4,
                         i_in_lane_3,  i_in_lane_2,  i_in_lane_1, i_in_lane_0};

    // round stages
    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        xoodoo_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[r]),
            .i_state (w_state[r]),
            .i_rc    (RC_TBL[r]),
            .o_vld   (w_vld[r+1]),
            .o_state (w_state[r+1])
        );
    end

    // result word
    assign o_valid       = w_vld[ROUNDS];
    assign o_out_lane_0  = w_state[ROUNDS][0];
    assign o_out_lane_1  = w_state[ROUNDS][1];
    assign o_out_lane_2  = w_state[ROUNDS][2];
    assign o_out_lane_3  = w_state[ROUNDS][3];
    assign o_out_lane_4  = w_state[ROUNDS][4];
    assign o_out_lane_5  = w_state[ROUNDS][5];
    assign o_out_lane_6  = w_state[ROUNDS][6];
    assign o_out_lane_7  = w_state[ROUNDS][7];
    assign o_out_lane_8  = w_state[ROUNDS][8];
    assign o_out_lane_9  = w_state[ROUNDS][9];
    assign o_out_lane_10 = w_state[ROUNDS][10];
    assign o_out_lane_11 = w_state[ROUNDS][11];

`ifndef SYNTHESIS
    // every result traces back to a word taken at the input out of reset
    a_res_has_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && i_rst_n, 12))
        else $error("result without source word");

    // first stage hands its word on
    a_stage_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[1] |=> w_vld[2])
        else $error("word lost after first stage");

    // last stage hands its word to the result port
    a_stage_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[ROUNDS-1] |=> o_valid)
        else $error("word lost before result port");
`endif

endmodule
